// File: sv/vrt_pkg.sv
// Shared types, codes and helpers for the verse reference translator.
// No dependencies; imported by vrt_table and verse_reference_translator.
package vrt_pkg;

    localparam logic [1:0] OP_LOAD_BOOK    = 2'd0;
    localparam logic [1:0] OP_LOAD_CHAPTER = 2'd1;
    localparam logic [1:0] OP_LOCATE       = 2'd2;
    localparam logic [1:0] OP_COMPOSE      = 2'd3;

    localparam logic [1:0] CFG_BOOK_COUNT     = 2'd0;
    localparam logic [1:0] CFG_CHAPTER_COUNT  = 2'd1;
    localparam logic [1:0] CFG_HEADING_MARKER = 2'd2;
    localparam logic [1:0] CFG_ABSENT_MARKER  = 2'd3;

    typedef struct packed {
        logic [15:0] start;
        logic [7:0]  limit;
    } vrt_entry_t;

    typedef struct packed {
        logic        start_search;
        logic        start_read;
        logic [15:0] key;
    } vrt_cmd_t;

    typedef struct packed {
        logic       done;
        vrt_entry_t entry;
    } vrt_rsp_t;

    function automatic logic [7:0] sat_diff8(input logic [15:0] a, input logic [15:0] b);
        logic [15:0] diff;
        diff = a - b;
        if (a < b) begin
            return 8'd0;
        end else if (diff > 16'd255) begin
            return 8'd255;
        end else begin
            return diff[7:0];
        end
    endfunction

endpackage

// File: sv/vrt_table.sv
// One table (start offset and limit per slot) in a synchronous memory,
// with a floor-search engine and a direct read. Depends on vrt_pkg.
module vrt_table #(
    parameter int DEPTH = 128
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  vrt_pkg::vrt_cmd_t                  cmd,
    input  logic [$clog2(DEPTH)-1:0]           last,
    input  logic [$clog2(DEPTH)-1:0]           addr,
    input  logic                               wr_en,
    input  logic [$clog2(DEPTH)-1:0]           wr_addr,
    input  vrt_pkg::vrt_entry_t                wr_entry,
    output vrt_pkg::vrt_rsp_t                  rsp,
    output logic [$clog2(DEPTH)-1:0]           slot
);
    import vrt_pkg::*;

    localparam int AW = $clog2(DEPTH);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_PROBE = 2'd1;
    localparam logic [1:0] ST_FINAL = 2'd2;
    localparam logic [1:0] ST_FETCH = 2'd3;

    vrt_entry_t mem [DEPTH];
    vrt_entry_t rd_data_reg;
    logic [AW-1:0] rd_addr;

    logic [1:0]    state_reg, state_next;
    logic [AW-1:0] low_reg, low_next;
    logic [AW-1:0] high_reg, high_next;
    logic [AW-1:0] mid_reg, mid_next;
    logic [15:0]   key_reg, key_next;

    logic          le;
    logic [AW-1:0] nl, nh, span, mid_n;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_entry;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign le    = rd_data_reg.start <= key_reg;
    assign nl    = le ? mid_reg : low_reg;
    assign nh    = le ? high_reg : mid_reg;
    assign span  = nh - nl;
    assign mid_n = nl + (span >> 1);

    always_comb begin
        state_next = state_reg;
        low_next   = low_reg;
        high_next  = high_reg;
        mid_next   = mid_reg;
        key_next   = key_reg;
        rd_addr    = low_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (cmd.start_search) begin
                    key_next  = cmd.key;
                    low_next  = '0;
                    high_next = last;
                    if (last > AW'(1)) begin
                        mid_next   = last >> 1;
                        rd_addr    = last >> 1;
                        state_next = ST_PROBE;
                    end else begin
                        rd_addr    = last;
                        state_next = ST_FINAL;
                    end
                end else if (cmd.start_read) begin
                    low_next   = addr;
                    rd_addr    = addr;
                    state_next = ST_FETCH;
                end
            end
            ST_PROBE: begin
                low_next  = nl;
                high_next = nh;
                if (span > AW'(1)) begin
                    mid_next = mid_n;
                    rd_addr  = mid_n;
                end else begin
                    rd_addr    = nh;
                    state_next = ST_FINAL;
                end
            end
            ST_FINAL: begin
                rd_addr    = low_reg;
                state_next = le ? ST_IDLE : ST_FETCH;
            end
            ST_FETCH: begin
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
        low_reg  <= low_next;
        high_reg <= high_next;
        mid_reg  <= mid_next;
        key_reg  <= key_next;
    end

    assign rsp.done  = (state_reg == ST_FETCH) || ((state_reg == ST_FINAL) && le);
    assign rsp.entry = rd_data_reg;
    assign slot      = (state_reg == ST_FETCH) ? low_reg : high_reg;

endmodule

// File: sv/verse_reference_translator.sv
// Top level: item sequencer, configuration registers and result register.
// Depends on vrt_pkg and vrt_table (book table and chapter table).
//
//  channel | ports             | transfer when
//  --------+-------------------+----------------------
//  input   | s_valid/s_ready   | s_valid && s_ready
//  result  | m_valid/m_ready   | m_valid && m_ready
//  config  | cfg_valid/ready   | cfg_valid && cfg_ready
//
// Load writes a table entry at the input transfer. Compose reads the book
// table, then the chapter table. Locate searches the chapter table, then the
// book table, one probe per cycle on each table's single read port.
// Reset is synchronous; table contents are not cleared.
// A waiting result does not block the next item; a finished item waits
// in its staging register until the result register is free.
module verse_reference_translator #(
    parameter int MAX_BOOKS         = 128,
    parameter int MAX_CHAPTER_SLOTS = 2048
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_opcode,
    input  logic [10:0] s_entry_slot,
    input  logic [15:0] s_entry_offset,
    input  logic [7:0]  s_entry_limit,
    input  logic [15:0] s_linear_index,
    input  logic [6:0]  s_book_number,
    input  logic [7:0]  s_chapter_number,
    input  logic [7:0]  s_verse_number,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [6:0]  m_found_book,
    output logic [7:0]  m_found_chapter,
    output logic [7:0]  m_found_verse,
    output logic [15:0] m_built_index,
    output logic [7:0]  m_chapters_in_book,
    output logic [7:0]  m_verses_in_chapter,
    output logic        m_book_present,
    output logic        m_range_error
);
    import vrt_pkg::*;

    localparam int BW = $clog2(MAX_BOOKS);
    localparam int CW = $clog2(MAX_CHAPTER_SLOTS);
    localparam logic [8:0]  BK_DEPTH = 9'(MAX_BOOKS);
    localparam logic [16:0] CH_DEPTH = 17'(MAX_CHAPTER_SLOTS);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_LOC_CH = 3'd1;
    localparam logic [2:0] ST_LOC_BK = 3'd2;
    localparam logic [2:0] ST_CMP_BK = 3'd3;
    localparam logic [2:0] ST_CMP_CH = 3'd4;
    localparam logic [2:0] ST_EMIT   = 3'd5;

    logic [7:0]  book_count_reg;
    logic [11:0] chapter_count_reg;
    logic [7:0]  heading_marker_reg;
    logic [15:0] absent_marker_reg;

    logic [2:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;

    logic [15:0] lin_reg, lin_next;
    logic [7:0]  ch_req_reg, ch_req_next;
    logic [7:0]  vs_req_reg, vs_req_next;
    logic [CW-1:0] ch_slot_reg, ch_slot_next;
    logic [15:0] ch_start_reg, ch_start_next;
    logic [7:0]  ch_limit_reg, ch_limit_next;

    logic [6:0]  res_book_reg, res_book_next;
    logic [7:0]  res_ch_reg, res_ch_next;
    logic [7:0]  res_vs_reg, res_vs_next;
    logic [15:0] res_idx_reg, res_idx_next;
    logic [7:0]  res_cib_reg, res_cib_next;
    logic [7:0]  res_vic_reg, res_vic_next;
    logic        res_pres_reg, res_pres_next;
    logic        res_err_reg, res_err_next;

    logic [6:0]  out_book_reg;
    logic [7:0]  out_ch_reg;
    logic [7:0]  out_vs_reg;
    logic [15:0] out_idx_reg;
    logic [7:0]  out_cib_reg;
    logic [7:0]  out_vic_reg;
    logic        out_pres_reg;
    logic        out_err_reg;

    logic [8:0]  bc_ext, book_last_full;
    logic [16:0] cc_ext, chap_last_full;
    logic [BW-1:0] book_last;
    logic [CW-1:0] chap_last;

    logic        in_xfer, out_free;
    logic [16:0] slot_ext17, slot_sum;
    logic [15:0] bk_req_ext, ch_slot_ext, bk_slot_ext, ch_slot_reg_ext;
    logic [16:0] idx_sum;
    logic        heading;

    vrt_cmd_t   bk_cmd, ch_cmd;
    vrt_rsp_t   bk_rsp, ch_rsp;
    logic [BW-1:0] bk_addr, bk_slot;
    logic [CW-1:0] ch_addr, ch_slot;
    logic       bk_wr_en, ch_wr_en;
    vrt_entry_t wr_entry;

    assign bc_ext = 9'(book_count_reg);
    assign cc_ext = 17'(chapter_count_reg);
    assign book_last_full = (book_count_reg == 8'd0) ? 9'd0 :
                            (bc_ext > BK_DEPTH) ? BK_DEPTH - 9'd1 : bc_ext - 9'd1;
    assign chap_last_full = (chapter_count_reg == 12'd0) ? 17'd0 :
                            (cc_ext > CH_DEPTH) ? CH_DEPTH - 17'd1 : cc_ext - 17'd1;
    assign book_last = book_last_full[BW-1:0];
    assign chap_last = chap_last_full[CW-1:0];

    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            book_count_reg     <= 8'd1;
            chapter_count_reg  <= 12'd1;
            heading_marker_reg <= 8'd255;
            absent_marker_reg  <= 16'hFFFF;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_BOOK_COUNT:     book_count_reg     <= cfg_data[7:0];
                CFG_CHAPTER_COUNT:  chapter_count_reg  <= cfg_data[11:0];
                CFG_HEADING_MARKER: heading_marker_reg <= cfg_data[7:0];
                CFG_ABSENT_MARKER:  absent_marker_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    assign s_ready  = (state_reg == ST_IDLE);
    assign in_xfer  = s_valid && s_ready;
    assign out_free = !out_valid_reg || m_ready;

    // load path
    assign slot_ext17     = 17'(s_entry_slot);
    assign wr_entry.start = s_entry_offset;
    assign wr_entry.limit = s_entry_limit;
    assign bk_wr_en = in_xfer && (s_opcode == OP_LOAD_BOOK) && (slot_ext17 < 17'(MAX_BOOKS));
    assign ch_wr_en = in_xfer && (s_opcode == OP_LOAD_CHAPTER) && (slot_ext17 < CH_DEPTH);

    assign bk_req_ext      = 16'(s_book_number);
    assign ch_slot_ext     = 16'(ch_slot);
    assign bk_slot_ext     = 16'(bk_slot);
    assign ch_slot_reg_ext = 16'(ch_slot_reg);
    assign slot_sum        = 17'(bk_rsp.entry.start) + 17'(ch_req_reg);
    assign idx_sum         = 17'(ch_rsp.entry.start) + 17'(vs_req_reg);
    assign heading         = bk_rsp.entry.limit == heading_marker_reg;

    always_comb begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        lin_next       = lin_reg;
        ch_req_next    = ch_req_reg;
        vs_req_next    = vs_req_reg;
        ch_slot_next   = ch_slot_reg;
        ch_start_next  = ch_start_reg;
        ch_limit_next  = ch_limit_reg;
        res_book_next  = res_book_reg;
        res_ch_next    = res_ch_reg;
        res_vs_next    = res_vs_reg;
        res_idx_next   = res_idx_reg;
        res_cib_next   = res_cib_reg;
        res_vic_next   = res_vic_reg;
        res_pres_next  = res_pres_reg;
        res_err_next   = res_err_reg;
        bk_cmd         = '0;
        ch_cmd         = '0;
        bk_addr        = bk_req_ext[BW-1:0];
        ch_addr        = slot_sum[CW-1:0];

        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (in_xfer) begin
                    lin_next      = s_linear_index;
                    ch_req_next   = s_chapter_number;
                    vs_req_next   = s_verse_number;
                    res_book_next = s_book_number;
                    res_ch_next   = s_chapter_number;
                    res_vs_next   = s_verse_number;
                    res_idx_next  = 16'd0;
                    res_cib_next  = 8'd0;
                    res_vic_next  = 8'd0;
                    res_pres_next = 1'b0;
                    res_err_next  = 1'b0;
                    if (s_opcode == OP_LOCATE) begin
                        ch_cmd.start_search = 1'b1;
                        ch_cmd.key          = s_linear_index;
                        state_next          = ST_LOC_CH;
                    end else if (s_opcode == OP_COMPOSE) begin
                        if (9'(s_book_number) > book_last_full) begin
                            res_err_next = 1'b1;
                            state_next   = ST_EMIT;
                        end else begin
                            bk_cmd.start_read = 1'b1;
                            state_next        = ST_CMP_BK;
                        end
                    end
                end
            end
            ST_LOC_CH: begin
                if (ch_rsp.done) begin
                    ch_slot_next        = ch_slot;
                    ch_start_next       = ch_rsp.entry.start;
                    ch_limit_next       = ch_rsp.entry.limit;
                    bk_cmd.start_search = 1'b1;
                    bk_cmd.key          = ch_slot_ext;
                    state_next          = ST_LOC_BK;
                end
            end
            ST_LOC_BK: begin
                if (bk_rsp.done) begin
                    res_book_next = bk_slot_ext[6:0];
                    res_idx_next  = lin_reg;
                    res_vic_next  = ch_limit_reg;
                    res_pres_next = bk_rsp.entry.start != absent_marker_reg;
                    if (heading) begin
                        res_ch_next  = 8'd0;
                        res_vs_next  = 8'd0;
                        res_cib_next = 8'd0;
                    end else begin
                        res_ch_next  = sat_diff8(ch_slot_reg_ext, bk_rsp.entry.start);
                        res_vs_next  = sat_diff8(lin_reg, ch_start_reg);
                        res_cib_next = bk_rsp.entry.limit;
                    end
                    state_next = ST_EMIT;
                end
            end
            ST_CMP_BK: begin
                if (bk_rsp.done) begin
                    res_cib_next  = heading ? 8'd0 : bk_rsp.entry.limit;
                    res_pres_next = bk_rsp.entry.start != absent_marker_reg;
                    if (slot_sum > chap_last_full) begin
                        res_err_next = 1'b1;
                        state_next   = ST_EMIT;
                    end else begin
                        ch_cmd.start_read = 1'b1;
                        state_next        = ST_CMP_CH;
                    end
                end
            end
            ST_CMP_CH: begin
                if (ch_rsp.done) begin
                    res_idx_next = idx_sum[16] ? 16'hFFFF : idx_sum[15:0];
                    res_vic_next = ch_rsp.entry.limit;
                    state_next   = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
        lin_reg      <= lin_next;
        ch_req_reg   <= ch_req_next;
        vs_req_reg   <= vs_req_next;
        ch_slot_reg  <= ch_slot_next;
        ch_start_reg <= ch_start_next;
        ch_limit_reg <= ch_limit_next;
        res_book_reg <= res_book_next;
        res_ch_reg   <= res_ch_next;
        res_vs_reg   <= res_vs_next;
        res_idx_reg  <= res_idx_next;
        res_cib_reg  <= res_cib_next;
        res_vic_reg  <= res_vic_next;
        res_pres_reg <= res_pres_next;
        res_err_reg  <= res_err_next;
        if ((state_reg == ST_EMIT) && out_free) begin
            out_book_reg <= res_book_reg;
            out_ch_reg   <= res_ch_reg;
            out_vs_reg   <= res_vs_reg;
            out_idx_reg  <= res_idx_reg;
            out_cib_reg  <= res_cib_reg;
            out_vic_reg  <= res_vic_reg;
            out_pres_reg <= res_pres_reg;
            out_err_reg  <= res_err_reg;
        end
    end

    assign m_valid             = out_valid_reg;
    assign m_found_book        = out_book_reg;
    assign m_found_chapter     = out_ch_reg;
    assign m_found_verse       = out_vs_reg;
    assign m_built_index       = out_idx_reg;
    assign m_chapters_in_book  = out_cib_reg;
    assign m_verses_in_chapter = out_vic_reg;
    assign m_book_present      = out_pres_reg;
    assign m_range_error       = out_err_reg;

    vrt_table #(
        .DEPTH (MAX_BOOKS)
    ) u_book_table (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (bk_cmd),
        .last     (book_last),
        .addr     (bk_addr),
        .wr_en    (bk_wr_en),
        .wr_addr  (slot_ext17[BW-1:0]),
        .wr_entry (wr_entry),
        .rsp      (bk_rsp),
        .slot     (bk_slot)
    );

    vrt_table #(
        .DEPTH (MAX_CHAPTER_SLOTS)
    ) u_chapter_table (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (ch_cmd),
        .last     (chap_last),
        .addr     (ch_addr),
        .wr_en    (ch_wr_en),
        .wr_addr  (slot_ext17[CW-1:0]),
        .wr_entry (wr_entry),
        .rsp      (ch_rsp),
        .slot     (ch_slot)
    );

    a_ch_done_owned: assert property (@(posedge aclk) disable iff (!aresetn)
        ch_rsp.done |-> (state_reg == ST_LOC_CH) || (state_reg == ST_CMP_CH))
        else $error("chapter table finished outside a chapter step");

    a_bk_done_owned: assert property (@(posedge aclk) disable iff (!aresetn)
        bk_rsp.done |-> (state_reg == ST_LOC_BK) || (state_reg == ST_CMP_BK))
        else $error("book table finished outside a book step");

    a_locate_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        in_xfer && (s_opcode == OP_LOCATE) |=> (state_reg == ST_LOC_CH))
        else $error("locate did not start the chapter search");

    a_emit_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT) && out_valid_reg && !m_ready |=> (state_reg == ST_EMIT))
        else $error("staged result dropped while result register busy");

    a_no_load_write_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (bk_wr_en || ch_wr_en) |-> !bk_cmd.start_search && !ch_cmd.start_search)
        else $error("table write overlaps a search start");

endmodule

// File: dv/verse_reference_translator_checker.sv
// Scoreboard for verse_reference_translator: mirrors the book and chapter tables, predicts
// every locate and compose result and compares transfers on the result channel.
// Depends on vrt_pkg for the configuration register codes.
`timescale 1ns / 100ps

module verse_reference_translator_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [1:0]  s_opcode,
    input  logic [10:0] s_entry_slot,
    input  logic [15:0] s_entry_offset,
    input  logic [7:0]  s_entry_limit,
    input  logic [15:0] s_linear_index,
    input  logic [6:0]  s_book_number,
    input  logic [7:0]  s_chapter_number,
    input  logic [7:0]  s_verse_number,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [6:0]  m_found_book,
    input  logic [7:0]  m_found_chapter,
    input  logic [7:0]  m_found_verse,
    input  logic [15:0] m_built_index,
    input  logic [7:0]  m_chapters_in_book,
    input  logic [7:0]  m_verses_in_chapter,
    input  logic        m_book_present,
    input  logic        m_range_error,
    output int unsigned mismatch_count,
    output int unsigned results_owed
);
    import vrt_pkg::*;

    localparam int unsigned BOOK_DEPTH    = 128;
    localparam int unsigned CHAPTER_DEPTH = 2048;

    typedef struct packed {
        logic [6:0]  book;
        logic [7:0]  chapter;
        logic [7:0]  verse;
        logic [15:0] index;
        logic [7:0]  chapters;
        logic [7:0]  verses;
        logic        present;
        logic        range_err;
    } verse_ref_t;

    logic [15:0] book_first     [BOOK_DEPTH];
    logic [7:0]  book_chapters  [BOOK_DEPTH];
    logic [15:0] chapter_first  [CHAPTER_DEPTH];
    logic [7:0]  chapter_verses [CHAPTER_DEPTH];

    logic [7:0]  book_count_r;
    logic [11:0] chapter_count_r;
    logic [7:0]  heading_r;
    logic [15:0] absent_r;

    verse_ref_t owed_refs[$];

    function automatic int unsigned used_count(input int unsigned n, input int unsigned depth);
        if (n == 0) begin
            return 1;
        end
        return (n > depth) ? depth : n;
    endfunction

    // largest entry whose start is <= key, entry 0 when none
    function automatic int unsigned floor_probe(input bit on_books, input int unsigned size,
                                                input int unsigned key);
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        lo = 0;
        hi = size - 1;
        while (hi - lo > 1) begin
            mid = lo + (hi - lo) / 2;
            if ((on_books ? book_first[mid] : chapter_first[mid]) <= key) begin
                lo = mid;
            end else begin
                hi = mid;
            end
        end
        return ((on_books ? book_first[hi] : chapter_first[hi]) <= key) ? hi : lo;
    endfunction

    function automatic logic [7:0] clipped_gap(input int unsigned a, input int unsigned b);
        if (a < b) begin
            return 8'd0;
        end
        return (a - b > 255) ? 8'd255 : 8'(a - b);
    endfunction

    task automatic take_item();
        verse_ref_t  want;
        int unsigned nb;
        int unsigned nc;
        int unsigned slot;
        int unsigned b;
        int unsigned sum;
        nb = used_count(book_count_r, BOOK_DEPTH);
        nc = used_count(chapter_count_r, CHAPTER_DEPTH);
        want = '0;
        case (s_opcode)
            OP_LOAD_BOOK: begin
                if (s_entry_slot < BOOK_DEPTH) begin
                    book_first[s_entry_slot]    = s_entry_offset;
                    book_chapters[s_entry_slot] = s_entry_limit;
                end
                return;
            end
            OP_LOAD_CHAPTER: begin
                chapter_first[s_entry_slot]  = s_entry_offset;
                chapter_verses[s_entry_slot] = s_entry_limit;
                return;
            end
            OP_LOCATE: begin
                slot = floor_probe(1'b0, nc, s_linear_index);
                b    = floor_probe(1'b1, nb, slot);
                want.book    = 7'(b);
                want.index   = s_linear_index;
                want.verses  = chapter_verses[slot];
                want.present = (book_first[b] != absent_r);
                if (book_chapters[b] != heading_r) begin
                    want.verse    = clipped_gap(s_linear_index, chapter_first[slot]);
                    want.chapter  = clipped_gap(slot, book_first[b]);
                    want.chapters = book_chapters[b];
                end
            end
            default: begin
                want.book    = s_book_number;
                want.chapter = s_chapter_number;
                want.verse   = s_verse_number;
                if (s_book_number >= nb) begin
                    want.range_err = 1'b1;
                end else begin
                    slot = book_first[s_book_number] + s_chapter_number;
                    want.present  = (book_first[s_book_number] != absent_r);
                    want.chapters = (book_chapters[s_book_number] == heading_r) ?
                                    8'd0 : book_chapters[s_book_number];
                    if (slot >= nc) begin
                        want.range_err = 1'b1;
                    end else begin
                        sum = chapter_first[slot] + s_verse_number;
                        want.index  = (sum > 65535) ? 16'hFFFF : 16'(sum);
                        want.verses = chapter_verses[slot];
                    end
                end
            end
        endcase
        owed_refs.push_back(want);
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    task automatic check_result();
        verse_ref_t want;
        if (owed_refs.size() == 0) begin
            $error("result transfer with no request pending");
            mismatch_count++;
            return;
        end
        want = owed_refs.pop_front();
        check_field("found_book", want.book, m_found_book);
        check_field("found_chapter", want.chapter, m_found_chapter);
        check_field("found_verse", want.verse, m_found_verse);
        check_field("built_index", want.index, m_built_index);
        check_field("chapters_in_book", want.chapters, m_chapters_in_book);
        check_field("verses_in_chapter", want.verses, m_verses_in_chapter);
        check_field("book_present", want.present, m_book_present);
        check_field("range_error", want.range_err, m_range_error);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            book_count_r    = 8'd1;
            chapter_count_r = 12'd1;
            heading_r       = 8'd255;
            absent_r        = 16'hFFFF;
            owed_refs.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_BOOK_COUNT:     book_count_r    = cfg_data[7:0];
                    CFG_CHAPTER_COUNT:  chapter_count_r = cfg_data[11:0];
                    CFG_HEADING_MARKER: heading_r       = cfg_data[7:0];
                    default:            absent_r        = cfg_data;
                endcase
            end
            if (m_valid && m_ready) begin
                check_result();
            end
            if (s_valid && s_ready) begin
                take_item();
            end
        end
        results_owed = owed_refs.size();
    end

endmodule

// File: dv/verse_reference_translator_tb.sv
// Testbench top for verse_reference_translator: clock, reset, configuration phases and
// table layouts, locate/compose traffic with idling on both channels, and the verdict.
// Depends on vrt_pkg and verse_reference_translator_checker.
`timescale 1ns / 100ps

module verse_reference_translator_tb;
    import vrt_pkg::*;

    typedef struct packed {
        logic [1:0]  op;
        logic [10:0] slot;
        logic [15:0] offset;
        logic [7:0]  limit;
        logic [15:0] lin;
        logic [6:0]  book;
        logic [7:0]  chapter;
        logic [7:0]  verse;
    } lookup_req_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = CFG_BOOK_COUNT;
    logic [15:0] cfg_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_opcode = OP_LOAD_BOOK;
    logic [10:0] s_entry_slot = '0;
    logic [15:0] s_entry_offset = '0;
    logic [7:0]  s_entry_limit = '0;
    logic [15:0] s_linear_index = '0;
    logic [6:0]  s_book_number = '0;
    logic [7:0]  s_chapter_number = '0;
    logic [7:0]  s_verse_number = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [6:0]  m_found_book;
    logic [7:0]  m_found_chapter;
    logic [7:0]  m_found_verse;
    logic [15:0] m_built_index;
    logic [7:0]  m_chapters_in_book;
    logic [7:0]  m_verses_in_chapter;
    logic        m_book_present;
    logic        m_range_error;

    int unsigned mismatch_count;
    int unsigned results_owed;

    int unsigned src_idle = 0;
    int unsigned sink_stall = 0;
    int unsigned hold_asks = 0;
    int unsigned hold_seen = 0;
    int unsigned hold_left = 0;

    int unsigned used_books = 1;
    int unsigned used_chapters = 1;
    logic [7:0]  heading_cur = 8'd255;
    logic [15:0] absent_cur = 16'hFFFF;
    int unsigned lay_top = 0;
    logic [15:0] lay_chap_first [2048];
    int unsigned lay_book_span  [128];

    always #6 aclk = ~aclk;

    verse_reference_translator uut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_opcode           (s_opcode),
        .s_entry_slot       (s_entry_slot),
        .s_entry_offset     (s_entry_offset),
        .s_entry_limit      (s_entry_limit),
        .s_linear_index     (s_linear_index),
        .s_book_number      (s_book_number),
        .s_chapter_number   (s_chapter_number),
        .s_verse_number     (s_verse_number),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_found_book       (m_found_book),
        .m_found_chapter    (m_found_chapter),
        .m_found_verse      (m_found_verse),
        .m_built_index      (m_built_index),
        .m_chapters_in_book (m_chapters_in_book),
        .m_verses_in_chapter(m_verses_in_chapter),
        .m_book_present     (m_book_present),
        .m_range_error      (m_range_error)
    );

    verse_reference_translator_checker u_checker (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_opcode           (s_opcode),
        .s_entry_slot       (s_entry_slot),
        .s_entry_offset     (s_entry_offset),
        .s_entry_limit      (s_entry_limit),
        .s_linear_index     (s_linear_index),
        .s_book_number      (s_book_number),
        .s_chapter_number   (s_chapter_number),
        .s_verse_number     (s_verse_number),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_found_book       (m_found_book),
        .m_found_chapter    (m_found_chapter),
        .m_found_verse      (m_found_verse),
        .m_built_index      (m_built_index),
        .m_chapters_in_book (m_chapters_in_book),
        .m_verses_in_chapter(m_verses_in_chapter),
        .m_book_present     (m_book_present),
        .m_range_error      (m_range_error),
        .mismatch_count     (mismatch_count),
        .results_owed       (results_owed)
    );

    // result side: random stalls, plus a long hold-off on request
    always @(negedge aclk) begin
        if (hold_seen != hold_asks) begin
            hold_seen <= hold_asks;
            hold_left <= 600;
            m_ready   <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= sink_stall);
        end
    end

    function automatic lookup_req_t noise_req();
        lookup_req_t r;
        r.op      = 2'($urandom);
        r.slot    = 11'($urandom);
        r.offset  = 16'($urandom);
        r.limit   = 8'($urandom);
        r.lin     = 16'($urandom);
        r.book    = 7'($urandom);
        r.chapter = 8'($urandom);
        r.verse   = 8'($urandom);
        return r;
    endfunction

    task automatic push_item(input lookup_req_t r);
        while ($urandom_range(99) < src_idle) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_opcode         <= r.op;
        s_entry_slot     <= r.slot;
        s_entry_offset   <= r.offset;
        s_entry_limit    <= r.limit;
        s_linear_index   <= r.lin;
        s_book_number    <= r.book;
        s_chapter_number <= r.chapter;
        s_verse_number   <= r.verse;
        s_valid          <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic load_entry(input logic [1:0] op, input int unsigned slot,
                              input int unsigned offset, input int unsigned limit);
        lookup_req_t r;
        r = noise_req();
        r.op     = op;
        r.slot   = 11'(slot);
        r.offset = 16'(offset);
        r.limit  = 8'(limit);
        push_item(r);
    endtask

    task automatic query(input logic [1:0] op, input int unsigned lin,
                         input int unsigned book, input int unsigned chapter,
                         input int unsigned verse);
        lookup_req_t r;
        r = noise_req();
        r.op      = op;
        r.lin     = 16'(lin);
        r.book    = 7'(book);
        r.chapter = 8'(chapter);
        r.verse   = 8'(verse);
        push_item(r);
    endtask

    // let the block drain before touching the registers
    task automatic settle();
        s_valid <= 1'b0;
        while (results_owed != 0) @(negedge aclk);
        repeat (40) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic configure(input int unsigned bc, input int unsigned cc,
                             input int unsigned hm, input int unsigned am);
        write_reg(CFG_BOOK_COUNT, 16'(($urandom & 32'hFF00) | bc));
        write_reg(CFG_CHAPTER_COUNT, 16'(($urandom & 32'hF000) | cc));
        write_reg(CFG_HEADING_MARKER, 16'(($urandom & 32'hFF00) | hm));
        write_reg(CFG_ABSENT_MARKER, 16'(am));
        cfg_valid <= 1'b0;
        used_books    = (bc == 0) ? 1 : ((bc > 128) ? 128 : bc);
        used_chapters = (cc == 0) ? 1 : ((cc > 2048) ? 2048 : cc);
        heading_cur   = 8'(hm);
        absent_cur    = 16'(am);
    endtask

    // sorted chapter starts, books spread over the chapter slots
    task automatic lay_out_tables(input int unsigned stride_cap);
        int unsigned pos;
        int unsigned stride;
        int unsigned cap;
        int unsigned first;
        int unsigned span;
        int unsigned limit;
        cap = 60000 / used_chapters;
        if (cap > stride_cap) cap = stride_cap;
        if (cap == 0) cap = 1;
        pos = $urandom_range(40);
        for (int unsigned s = 0; s < used_chapters; s++) begin
            stride = $urandom_range(cap, 1);
            lay_chap_first[s] = 16'(pos);
            load_entry(OP_LOAD_CHAPTER, s, pos, (stride > 255) ? 255 : stride);
            pos = pos + stride;
            if (pos > 65535) pos = 65535;
        end
        lay_top = pos;
        first = $urandom_range(1);
        for (int unsigned b = 0; b < used_books; b++) begin
            span = $urandom_range(2 * used_chapters / used_books + 1);
            lay_book_span[b] = span;
            limit = (span > 255) ? 255 : span;
            if ($urandom_range(9) == 0) limit = heading_cur;
            load_entry(OP_LOAD_BOOK, b, ($urandom_range(12) == 0) ? absent_cur : first, limit);
            first = first + span;
        end
    endtask

    task automatic random_ops(input int unsigned count);
        lookup_req_t r;
        int unsigned pick;
        int unsigned near;
        for (int unsigned i = 0; i < count; i++) begin
            r = noise_req();
            pick = $urandom_range(99);
            if (pick < 45) begin
                r.op = OP_LOCATE;
                near = lay_chap_first[$urandom_range(used_chapters - 1)] + $urandom_range(2);
                case ($urandom_range(3))
                    0: ;
                    1: r.lin = 16'((near > 65535) ? 65535 : near);
                    2: r.lin = 16'($urandom_range((lay_top + 50 > 65535) ? 65535 : lay_top + 50));
                    default: r.lin = lay_chap_first[$urandom_range(used_chapters - 1)];
                endcase
            end else if (pick < 90) begin
                r.op = OP_COMPOSE;
                if ($urandom_range(9) != 0) begin
                    r.book = 7'($urandom_range(used_books - 1));
                    if ($urandom_range(4) != 0) begin
                        r.chapter = 8'($urandom_range((lay_book_span[r.book] > 255) ?
                                                      255 : lay_book_span[r.book]));
                    end
                end
            end else if (pick < 95) begin
                r.op = OP_LOAD_CHAPTER;
            end else begin
                r.op = OP_LOAD_BOOK;
                if ($urandom_range(1) == 0) r.slot = 11'($urandom_range(used_books - 1));
                if ($urandom_range(3) == 0) r.offset = absent_cur;
                if ($urandom_range(3) == 0) r.limit = heading_cur;
            end
            push_item(r);
        end
    endtask

    task automatic run_phase(input int unsigned bc, input int unsigned cc,
                             input int unsigned hm, input int unsigned am,
                             input int unsigned stride_cap, input int unsigned ops,
                             input int unsigned mode, input bit squeeze);
        case (mode)
            0: begin src_idle = 0;  sink_stall <= 0;  end
            1: begin src_idle = 52; sink_stall <= 0;  end
            2: begin src_idle = 0;  sink_stall <= 52; end
            default: begin src_idle = 9; sink_stall <= 9; end
        endcase
        configure(bc, cc, hm, am);
        lay_out_tables(stride_cap);
        if (squeeze) begin
            hold_asks <= hold_asks + 1;
            random_ops(40);
        end
        random_ops(ops);
        settle();
    endtask

    task automatic directed_items();
        load_entry(OP_LOAD_BOOK, 0, 0, 3);
        load_entry(OP_LOAD_CHAPTER, 0, 10, 20);
        query(OP_LOCATE, 0, 0, 0, 0);
        query(OP_LOCATE, 10, 0, 0, 0);
        query(OP_LOCATE, 65535, 0, 0, 0);
        query(OP_COMPOSE, 0, 0, 0, 0);
        query(OP_COMPOSE, 0, 127, 0, 0);
        query(OP_COMPOSE, 0, 0, 1, 0);
        query(OP_COMPOSE, 0, 0, 255, 255);
        load_entry(OP_LOAD_CHAPTER, 0, 65500, 255);
        query(OP_COMPOSE, 0, 0, 0, 255);
        load_entry(OP_LOAD_BOOK, 2047, 7, 9);
        query(OP_LOCATE, 65535, 0, 0, 0);
        load_entry(OP_LOAD_BOOK, 0, 0, 255);
        query(OP_LOCATE, 65520, 0, 0, 0);
        query(OP_COMPOSE, 0, 0, 0, 3);
        load_entry(OP_LOAD_BOOK, 0, 65535, 5);
        query(OP_LOCATE, 100, 0, 0, 0);
        query(OP_COMPOSE, 0, 0, 0, 0);
        load_entry(OP_LOAD_BOOK, 127, 1, 1);
        settle();
    endtask

    initial begin
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        directed_items();
        // first phase fills the book table completely
        run_phase(128, 200, 255, 65535, 30, 100, 0, 1'b1);
        run_phase(0, 0, 0, 0, 300, 80, 1, 1'b0);
        run_phase(255, 130, 7, 40000, 29, 60, 2, 1'b0);
        run_phase(5, 40, 255, 65535, 400, 150, 3, 1'b0);
        run_phase(2, 2, 3, 65535, 300, 100, 0, 1'b0);
        run_phase($urandom_range(128, 1), $urandom_range(200, 1), $urandom_range(255),
                  65535, 20, 100, 1, 1'b0);
        run_phase(20, 140, 255, 0, 10, 80, 2, 1'b0);
        run_phase(17, 100, 200, 65535, 120, 80, 3, 1'b0);
        if (mismatch_count == 0) begin
            $display("verse_reference_translator regression: pass");
        end else begin
            $display("verse_reference_translator regression: fail");
        end
        $finish;
    end

    initial begin
        #30_000_000;
        $display("verse_reference_translator regression: fail");
        $finish;
    end

endmodule
